### design/file_block_map_walker_core_assert.svh
// Assertion macros used by the block's checker.
`ifndef FILE_BLOCK_MAP_WALKER_CORE_ASSERT_SVH
`define FILE_BLOCK_MAP_WALKER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define FBMW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fbmw check failed");

// Next-cycle implication, masked during reset.
`define FBMW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fbmw check failed");

`endif

### design/fbmw_pkg.sv
// Shared types and constants of the file block map walker.
package fbmw_pkg;

  localparam int NUM_INDEX_BLOCKS_DEF = 64;
  localparam int PTRS_PER_BLOCK = 256;
  localparam int SLOT_W = 8;
  localparam int ROOT_DEPTH = 15;
  localparam int ROOT_AW = 4;
  localparam int FB_W = 25;
  localparam int OFF_W = 24;
  localparam int LEVEL_W = 2;

  localparam logic [FB_W-1:0] FB_SINGLE_START = 25'd12;
  localparam logic [FB_W-1:0] FB_DOUBLE_START = 25'd268;
  localparam logic [FB_W-1:0] FB_TRIPLE_START = 25'd65804;
  localparam logic [FB_W-1:0] FB_TRIPLE_END   = 25'd16843020;

  localparam logic [ROOT_AW-1:0] ROOT_SINGLE = 4'd12;
  localparam logic [ROOT_AW-1:0] ROOT_DOUBLE = 4'd13;
  localparam logic [ROOT_AW-1:0] ROOT_TRIPLE = 4'd14;
  localparam logic [ROOT_AW-1:0] ROOT_LAST   = 4'd14;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_ROOT_WR   = 2'd0,
    KIND_STORE_WR  = 2'd1,
    KIND_TRANSLATE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BADPTR = 2'd2
  } status_t;

endpackage

### design/fbmw_root_mem.sv
// Root pointer table: 15-entry synchronous memory, entries read as all ones until written.
module fbmw_root_mem
  import fbmw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [ROOT_AW-1:0] waddr,
  input  logic [31:0]        wdata,
  input  logic               re,
  input  logic [ROOT_AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0]           mem [ROOT_DEPTH];
  logic [ROOT_DEPTH-1:0] written;
  logic [31:0]           rdata_raw;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_raw <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      if (re) begin
        rd_written <= written[raddr];
      end
    end
  end

  assign rdata = rd_written ? rdata_raw : ALL_ONES;

endmodule

### design/fbmw_store_mem.sv
// Index-block store: one write port, one registered read port.
module fbmw_store_mem
  import fbmw_pkg::*;
#(
  parameter int NumIndexBlocks = NUM_INDEX_BLOCKS_DEF
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [$clog2(NumIndexBlocks)+SLOT_W-1:0]    waddr,
  input  logic [31:0]                                 wdata,
  input  logic                                        re,
  input  logic [$clog2(NumIndexBlocks)+SLOT_W-1:0]    raddr,
  output logic [31:0]                                 rdata
);

  localparam int Depth = NumIndexBlocks * PTRS_PER_BLOCK;

  logic [31:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/fbmw_walker.sv
// Walk sequencer: decodes a translate request, chases pointers, holds the result.
module fbmw_walker
  import fbmw_pkg::*;
#(
  parameter int NumIndexBlocks = NUM_INDEX_BLOCKS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic [1:0]                                  kind,
  input  logic [FB_W-1:0]                             file_block,
  output logic                                        in_stall,
  input  logic [31:0]                                 root_rdata,
  input  logic [31:0]                                 store_rdata,
  output logic                                        root_re,
  output logic [ROOT_AW-1:0]                          root_raddr,
  output logic                                        store_re,
  output logic [$clog2(NumIndexBlocks)+SLOT_W-1:0]    store_raddr,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [31:0]                                 physical_block,
  output logic [1:0]                                  status
);

  localparam int BlkW = $clog2(NumIndexBlocks);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROOT  = 3'b010,
    S_STORE = 3'b100
  } walk_state_t;

  walk_state_t          state, state_next;
  logic [LEVEL_W-1:0]   level, level_next;
  logic [OFF_W-1:0]     off, off_next;
  logic                 oor, oor_next;
  logic                 out_valid_next;
  logic [31:0]          physical_block_next;
  logic [1:0]           status_next;

  logic [FB_W-1:0]      b1, b2, b3;
  logic [LEVEL_W-1:0]   dec_level;
  logic [OFF_W-1:0]     dec_off;
  logic                 dec_oor;
  logic [31:0]          cur;
  logic                 cur_ok;
  logic [SLOT_W-1:0]    slot;
  logic                 out_free;

  // Range decode of the logical block number.
  always_comb begin
    b1 = file_block - FB_SINGLE_START;
    b2 = file_block - FB_DOUBLE_START;
    b3 = file_block - FB_TRIPLE_START;
    dec_oor = 1'b0;
    if (file_block < FB_SINGLE_START) begin
      root_raddr = file_block[ROOT_AW-1:0];
      dec_level  = 2'd0;
      dec_off    = '0;
    end else if (file_block < FB_DOUBLE_START) begin
      root_raddr = ROOT_SINGLE;
      dec_level  = 2'd1;
      dec_off    = {16'd0, b1[7:0]};
    end else if (file_block < FB_TRIPLE_START) begin
      root_raddr = ROOT_DOUBLE;
      dec_level  = 2'd2;
      dec_off    = {8'd0, b2[15:0]};
    end else begin
      root_raddr = ROOT_TRIPLE;
      dec_level  = 2'd3;
      dec_off    = b3[OFF_W-1:0];
      dec_oor    = (file_block >= FB_TRIPLE_END);
    end
  end

  always_comb begin
    case (level)
      2'd3:    slot = off[23:16];
      2'd2:    slot = off[15:8];
      default: slot = off[7:0];
    endcase
  end

  assign cur         = (state == S_ROOT) ? root_rdata : store_rdata;
  assign cur_ok      = (cur < 32'(NumIndexBlocks));
  assign store_raddr = {cur[BlkW-1:0], slot};
  assign out_free    = !out_valid || !out_stall;
  assign in_stall    = (state != S_IDLE);

  always_comb begin
    state_next          = state;
    level_next          = level;
    off_next            = off;
    oor_next            = oor;
    out_valid_next      = out_valid && out_stall;
    physical_block_next = physical_block;
    status_next         = status;
    root_re             = 1'b0;
    store_re            = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && kind_t'(kind) == KIND_TRANSLATE) begin
          root_re    = 1'b1;
          level_next = dec_level;
          off_next   = dec_off;
          oor_next   = dec_oor;
          state_next = S_ROOT;
        end
      end
      S_ROOT, S_STORE: begin
        if (!oor && level != 2'd0 && cur_ok) begin
          store_re   = 1'b1;
          level_next = level - 2'd1;
          state_next = S_STORE;
        end else if (out_free) begin
          // Result register free: retire the walk. Otherwise memory data holds.
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
          if (oor) begin
            physical_block_next = ALL_ONES;
            status_next         = ST_RANGE;
          end else if (level != 2'd0) begin
            physical_block_next = ALL_ONES;
            status_next         = ST_BADPTR;
          end else begin
            physical_block_next = cur;
            status_next         = ST_OK;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    level          <= level_next;
    off            <= off_next;
    oor            <= oor_next;
    physical_block <= physical_block_next;
    status         <= status_next;
  end

endmodule

### design/file_block_map_walker_core.sv
// Top level of the file block map walker: write decode, memories and walk sequencer.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------------------------
//  in      | in_valid  | in_stall  | kind root_index store_block word_offset
//          |           |           | write_value file_block
//  out     | out_valid | out_stall | physical_block status
//
// Table and store writes complete when accepted. A translate request holds the input until
// its walk retires: a root read, then one store read per level walked (none when out of range),
// paced by the dependent reads of the single store read port.
// The result register lets the next request in while a result waits; a finished walk
// stalls only if the previous result has not been taken yet.
// Reset clears control and the root table valid bits; the store has no clearing pass.
module file_block_map_walker_core
  import fbmw_pkg::*;
#(
  parameter int NumIndexBlocks = NUM_INDEX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [3:0]        root_index,
  input  logic [5:0]        store_block,
  input  logic [7:0]        word_offset,
  input  logic [31:0]       write_value,
  input  logic [FB_W-1:0]   file_block,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       physical_block,
  output logic [1:0]        status
);

  localparam int BlkW = $clog2(NumIndexBlocks);
  localparam int StoreAw = BlkW + SLOT_W;

  logic                 accept;
  logic                 root_we;
  logic                 store_we;
  logic [31:0]          sb_wide;
  logic [StoreAw-1:0]   store_waddr;
  logic                 root_re;
  logic [ROOT_AW-1:0]   root_raddr;
  logic [31:0]          root_rdata;
  logic                 store_re;
  logic [StoreAw-1:0]   store_raddr;
  logic [31:0]          store_rdata;

  assign accept      = in_valid && !in_stall;
  assign sb_wide     = 32'(store_block);
  assign store_waddr = {sb_wide[BlkW-1:0], word_offset};
  assign root_we     = accept && kind_t'(kind) == KIND_ROOT_WR && root_index <= ROOT_LAST;
  assign store_we    = accept && kind_t'(kind) == KIND_STORE_WR &&
                       sb_wide < 32'(NumIndexBlocks);

  fbmw_root_mem u_root (
    .clk   (clk),
    .rst   (rst),
    .we    (root_we),
    .waddr (root_index),
    .wdata (write_value),
    .re    (root_re),
    .raddr (root_raddr),
    .rdata (root_rdata)
  );

  fbmw_store_mem #(
    .NumIndexBlocks (NumIndexBlocks)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (write_value),
    .re    (store_re),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  fbmw_walker #(
    .NumIndexBlocks (NumIndexBlocks)
  ) u_walker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .kind           (kind),
    .file_block     (file_block),
    .in_stall       (in_stall),
    .root_rdata     (root_rdata),
    .store_rdata    (store_rdata),
    .root_re        (root_re),
    .root_raddr     (root_raddr),
    .store_re       (store_re),
    .store_raddr    (store_raddr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .physical_block (physical_block),
    .status         (status)
  );

endmodule

### design/fbmw_checker.sv
// Port-level checks of the file block map walker, bound to the top level.
`include "file_block_map_walker_core_assert.svh"

module fbmw_checker
  import fbmw_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [1:0]        kind,
  input logic              out_valid,
  input logic              out_stall,
  input logic [31:0]       physical_block,
  input logic [1:0]        status
);

  // A translate request always occupies the walker for at least the root read.
  `FBMW_ASSERT_NEXT(a_translate_busy, clk, rst,
    in_valid && !in_stall && kind == KIND_TRANSLATE, in_stall)

  // Error results carry an all-ones block number.
  `FBMW_ASSERT_NOW(a_error_ones, clk, rst,
    out_valid && status != ST_OK, physical_block == ALL_ONES)

  `FBMW_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  `FBMW_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall,
    $stable(physical_block) && $stable(status))

endmodule

bind file_block_map_walker_core fbmw_checker u_fbmw_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .kind           (kind),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .physical_block (physical_block),
  .status         (status)
);

### test/file_block_map_walker_core_tb.sv
// Self-checking testbench for the file block map walker: directed and random requests.
module file_block_map_walker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbmw_pkg::*;

  localparam int NUM_BLOCKS = 64;
  localparam int STORE_WORDS = NUM_BLOCKS * PTRS_PER_BLOCK;
  localparam int unsigned SINGLE_FIRST = 12;
  localparam int unsigned DOUBLE_FIRST = SINGLE_FIRST + 256;
  localparam int unsigned TRIPLE_FIRST = DOUBLE_FIRST + 65536;
  localparam int unsigned BEYOND_FIRST = TRIPLE_FIRST + (1 << 24);
  localparam int unsigned FB_LAST = (1 << FB_W) - 1;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 150;

  typedef enum logic [2:0] {
    SPAN_DIRECT = 3'd0,
    SPAN_SINGLE = 3'd1,
    SPAN_DOUBLE = 3'd2,
    SPAN_TRIPLE = 3'd3,
    SPAN_BEYOND = 3'd4
  } span_t;

  typedef struct {
    logic [31:0] phys;
    status_t     st;
  } xlat_t;

  class map_scoreboard;
    logic [31:0] root_tab [ROOT_DEPTH];
    logic [31:0] store_words [STORE_WORDS];
    bit          word_set [STORE_WORDS];
    xlat_t       expected [$];
    int          mismatches;

    function new();
      for (int i = 0; i < ROOT_DEPTH; i++) root_tab[i] = ALL_ONES;
      for (int i = 0; i < STORE_WORDS; i++) word_set[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Which pointer span a file block falls in, and its offset within it.
    function span_t locate(input logic [FB_W-1:0] fb, output logic [23:0] off);
      off = '0;
      if (fb < SINGLE_FIRST) return SPAN_DIRECT;
      if (fb < DOUBLE_FIRST) begin
        off = 24'(fb - SINGLE_FIRST);
        return SPAN_SINGLE;
      end
      if (fb < TRIPLE_FIRST) begin
        off = 24'(fb - DOUBLE_FIRST);
        return SPAN_DOUBLE;
      end
      if (fb < BEYOND_FIRST) begin
        off = 24'(fb - TRIPLE_FIRST);
        return SPAN_TRIPLE;
      end
      return SPAN_BEYOND;
    endfunction

    function void map_block(input logic [FB_W-1:0] fb, output logic [31:0] phys,
                            output status_t st);
      logic [23:0] off;
      logic [7:0]  slot;
      logic [31:0] ptr;
      span_t       span;
      int          lvl;
      span = locate(fb, off);
      st = ST_OK;
      ptr = ALL_ONES;
      if (span == SPAN_BEYOND) begin
        st = ST_RANGE;
      end else if (span == SPAN_DIRECT) begin
        ptr = root_tab[fb[3:0]];
      end else begin
        lvl = int'(span);
        ptr = root_tab[ROOT_SINGLE + lvl - 1];
        while (lvl > 0 && st == ST_OK) begin
          // only index pointers are range checked, never the final data pointer
          if (ptr >= NUM_BLOCKS) begin
            st = ST_BADPTR;
          end else begin
            slot = 8'(off >> (8 * (lvl - 1)));
            ptr = store_words[{ptr[5:0], slot}];
            lvl--;
          end
        end
      end
      phys = (st == ST_OK) ? ptr : ALL_ONES;
    endfunction

    function void note_request(input logic [1:0] k, input logic [3:0] ri,
                               input logic [5:0] blk, input logic [7:0] wo,
                               input logic [31:0] wv, input logic [FB_W-1:0] fb);
      xlat_t want;
      case (k)
        KIND_ROOT_WR: begin
          if (ri <= ROOT_LAST) root_tab[ri] = wv;
        end
        KIND_STORE_WR: begin
          if (blk < NUM_BLOCKS) begin
            store_words[{blk, wo}] = wv;
            word_set[{blk, wo}] = 1'b1;
          end
        end
        KIND_TRANSLATE: begin
          map_block(fb, want.phys, want.st);
          expected.push_back(want);
        end
        default: ;
      endcase
    endfunction

    function void check_result(input logic [31:0] phys, input logic [1:0] st);
      xlat_t want;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: physical_block=%h status=%0d", phys, st);
      end else begin
        want = expected.pop_front();
        if (phys !== want.phys || st !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: physical_block exp %h got %h, status exp %0d got %0d",
                     want.phys, phys, want.st, st);
        end
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       kind = '0;
  logic [3:0]       root_index = '0;
  logic [5:0]       store_block = '0;
  logic [7:0]       word_offset = '0;
  logic [31:0]      write_value = '0;
  logic [FB_W-1:0]  file_block = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      physical_block;
  logic [1:0]       status;

  map_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accepted_items = 0;

  file_block_map_walker_core #(
    .NumIndexBlocks(NUM_BLOCKS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .root_index(root_index),
    .store_block(store_block),
    .word_offset(word_offset),
    .write_value(write_value),
    .file_block(file_block),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .physical_block(physical_block),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = !rst && recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(physical_block, status);
  end

  // Called just after a falling edge; returns just after the falling edge past acceptance.
  task automatic send_request(input logic [1:0] k, input logic [3:0] ri,
                              input logic [5:0] blk, input logic [7:0] wo,
                              input logic [31:0] wv, input logic [FB_W-1:0] fb);
    while (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    root_index = ri;
    store_block = blk;
    word_offset = wo;
    write_value = wv;
    file_block = fb;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, ri, blk, wo, wv, fb);
    if (k != KIND_UNUSED && !(k == KIND_ROOT_WR && ri > ROOT_LAST)) accepted_items++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Fields that a kind does not use carry random noise.
  task automatic root_write(input logic [3:0] ri, input logic [31:0] v);
    send_request(KIND_ROOT_WR, ri, 6'($urandom), 8'($urandom), v, FB_W'($urandom));
  endtask

  task automatic store_write(input logic [5:0] blk, input logic [7:0] wo,
                             input logic [31:0] v);
    send_request(KIND_STORE_WR, 4'($urandom), blk, wo, v, FB_W'($urandom));
  endtask

  task automatic translate(input logic [FB_W-1:0] fb);
    send_request(KIND_TRANSLATE, 4'($urandom), 6'($urandom), 8'($urandom), $urandom, fb);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly index pointers inside the store, some that leave it.
  function automatic logic [31:0] pick_pointer();
    case ($urandom_range(0, 19))
      0: return NUM_BLOCKS;
      1: return $urandom;
      default: return $urandom_range(0, NUM_BLOCKS - 1);
    endcase
  endfunction

  function automatic logic [FB_W-1:0] block_in_span(input span_t span);
    case (span)
      SPAN_DIRECT: return FB_W'($urandom_range(0, SINGLE_FIRST - 1));
      SPAN_SINGLE: return FB_W'($urandom_range(SINGLE_FIRST, DOUBLE_FIRST - 1));
      SPAN_DOUBLE: return FB_W'($urandom_range(DOUBLE_FIRST, TRIPLE_FIRST - 1));
      SPAN_TRIPLE: return FB_W'($urandom_range(TRIPLE_FIRST, BEYOND_FIRST - 1));
      default: return FB_W'($urandom_range(BEYOND_FIRST, FB_LAST));
    endcase
  endfunction

  // Writes every store word the walk for fb will read that is still unset (and
  // rewrites the first one now and then), so a translate never touches an unset word.
  // Deeper words are never rewritten: they may alias a word already on the path.
  task automatic prepare_walk(input logic [FB_W-1:0] fb, input bit fix_root);
    logic [23:0] off;
    logic [7:0]  slot;
    logic [31:0] ptr;
    logic [3:0]  ri;
    span_t       span;
    int          lvl;
    span = sb.locate(fb, off);
    if (span != SPAN_DIRECT && span != SPAN_BEYOND) begin
      lvl = int'(span);
      ri = 4'(ROOT_SINGLE + lvl - 1);
      if (fix_root && (sb.root_tab[ri] >= NUM_BLOCKS || $urandom_range(0, 7) == 0))
        root_write(ri, $urandom_range(0, NUM_BLOCKS - 1));
      ptr = sb.root_tab[ri];
      while (lvl > 0 && ptr < NUM_BLOCKS) begin
        slot = 8'(off >> (8 * (lvl - 1)));
        if (!sb.word_set[{ptr[5:0], slot}] ||
            (lvl == int'(span) && $urandom_range(0, 4) == 0))
          store_write(ptr[5:0], slot, (lvl > 1) ? pick_pointer() : $urandom);
        ptr = sb.store_words[{ptr[5:0], slot}];
        lvl--;
      end
    end
  endtask

  task automatic directed_requests();
    translate('0);
    translate(FB_W'(SINGLE_FIRST));
    translate(FB_W'(BEYOND_FIRST));
    translate(FB_W'(FB_LAST));
    send_request(KIND_UNUSED, 4'hF, 6'h3F, 8'hFF, ALL_ONES, FB_W'(FB_LAST));
    root_write(4'd15, 32'd0);
    translate(FB_W'(SINGLE_FIRST - 1));
    root_write(4'd0, 32'd0);
    root_write(4'd11, 32'hA5A5_5A5A);
    translate('0);
    translate(FB_W'(SINGLE_FIRST - 1));
    // single indirect at both ends of its span, final pointer all ones is not checked
    root_write(ROOT_SINGLE, NUM_BLOCKS - 1);
    store_write(6'd63, 8'd0, 32'd0);
    store_write(6'd63, 8'd255, ALL_ONES);
    translate(FB_W'(SINGLE_FIRST));
    translate(FB_W'(DOUBLE_FIRST - 1));
    // double indirect: bad intermediate pointer, then a good walk
    root_write(ROOT_DOUBLE, 32'd0);
    store_write(6'd0, 8'd0, NUM_BLOCKS);
    translate(FB_W'(DOUBLE_FIRST));
    store_write(6'd0, 8'd255, 32'd1);
    store_write(6'd1, 8'd255, 32'h1234_5678);
    translate(FB_W'(TRIPLE_FIRST - 1));
    // triple indirect: bad root pointer, then first and last blocks of the span
    root_write(ROOT_TRIPLE, NUM_BLOCKS);
    translate(FB_W'(TRIPLE_FIRST));
    root_write(ROOT_TRIPLE, 32'd2);
    store_write(6'd2, 8'd0, 32'd3);
    store_write(6'd3, 8'd0, 32'd4);
    store_write(6'd4, 8'd0, 32'hDEAD_BEEF);
    translate(FB_W'(TRIPLE_FIRST));
    store_write(6'd2, 8'd255, 32'd2);
    translate(FB_W'(BEYOND_FIRST - 1));
  endtask

  task automatic random_requests(input int count);
    int target;
    int pick;
    logic [FB_W-1:0] fb;
    target = accepted_items + count;
    while (accepted_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        fb = block_in_span(span_t'($urandom_range(0, 3)));
        prepare_walk(fb, 1'b1);
        translate(fb);
      end else if (pick < 55) begin
        fb = FB_W'($urandom_range(0, FB_LAST));
        prepare_walk(fb, 1'b0);
        translate(fb);
      end else if (pick < 70) begin
        root_write(4'($urandom_range(0, 15)),
                   $urandom_range(0, 1) ? pick_pointer() : $urandom);
      end else if (pick < 85) begin
        store_write(6'($urandom_range(0, NUM_BLOCKS - 1)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 1) ? pick_pointer() : $urandom);
      end else if (pick < 92) begin
        send_request(KIND_UNUSED, 4'($urandom), 6'($urandom), 8'($urandom), $urandom,
                     FB_W'($urandom));
      end else begin
        translate(block_in_span(SPAN_BEYOND));
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_requests();
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      random_requests(ITEMS_PER_PHASE);
      // hold off until the block has handed back everything in flight
      drain();
    end
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("file_block_map_walker_core_tb: clean");
    else
      $display("file_block_map_walker_core_tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("file_block_map_walker_core_tb: errors");
    $finish;
  end

endmodule
